/* hw/rtl/yuvrgb_pkg.sv */
package yuvrgb_pkg;

  // Signed width of one constant-gain product (sample offset times gain).
  localparam int PROD_W = 19;
  // Signed width of a scaled term and of a channel sum before clamping.
  localparam int TERM_W = 11;

  localparam logic [7:0] LUMA_OFS = 8'd16;

  localparam logic signed [PROD_W-1:0] LUMA_GAIN = 19'sd298;
  localparam logic signed [PROD_W-1:0] CR_TO_R   = 19'sd459;
  localparam logic signed [PROD_W-1:0] CB_TO_B   = 19'sd541;
  localparam logic signed [PROD_W-1:0] CB_TO_G   = -19'sd55;
  localparam logic signed [PROD_W-1:0] CR_TO_G   = -19'sd137;

  typedef struct packed {
    logic [7:0] luma_first;
    logic [7:0] luma_second;
    logic [7:0] chroma_blue;
    logic [7:0] chroma_red;
  } yuvrgb_in_t;

  typedef struct packed {
    logic [7:0] red_first;
    logic [7:0] green_first;
    logic [7:0] blue_first;
    logic [7:0] red_second;
    logic [7:0] green_second;
    logic [7:0] blue_second;
  } yuvrgb_out_t;

endpackage

/* hw/rtl/yuvrgb_conv.sv */
module yuvrgb_conv (
  input  yuvrgb_pkg::yuvrgb_in_t  pix_in,
  output yuvrgb_pkg::yuvrgb_out_t pix_out
);

  // Divide by 256 rounding toward zero: bias negative products before the shift.
  function automatic logic signed [yuvrgb_pkg::TERM_W-1:0] div256(
    input logic signed [yuvrgb_pkg::PROD_W-1:0] p
  );
    logic signed [yuvrgb_pkg::PROD_W-1:0] b;
    begin
      b = p[yuvrgb_pkg::PROD_W-1] ? (p + 19'sd255) : p;
      return $signed(b[yuvrgb_pkg::PROD_W-1:8]);
    end
  endfunction

  function automatic logic [7:0] clamp8(input logic signed [yuvrgb_pkg::TERM_W-1:0] v);
    logic [7:0] r;
    begin
      if (v[yuvrgb_pkg::TERM_W-1]) begin
        r = 8'd0;
      end else if (v[yuvrgb_pkg::TERM_W-2:8] != '0) begin
        r = 8'd255;
      end else begin
        r = v[7:0];
      end
      return r;
    end
  endfunction

  logic signed [7:0] cb_s;
  logic signed [7:0] cr_s;
  logic signed [8:0] y0_s;
  logic signed [8:0] y1_s;

  logic signed [yuvrgb_pkg::TERM_W-1:0] r_term;
  logic signed [yuvrgb_pkg::TERM_W-1:0] g_term;
  logic signed [yuvrgb_pkg::TERM_W-1:0] b_term;
  logic signed [yuvrgb_pkg::TERM_W-1:0] l0_term;
  logic signed [yuvrgb_pkg::TERM_W-1:0] l1_term;

  // Offset-128 chroma to two's complement: flip the top bit.
  assign cb_s = $signed({~pix_in.chroma_blue[7], pix_in.chroma_blue[6:0]});
  assign cr_s = $signed({~pix_in.chroma_red[7], pix_in.chroma_red[6:0]});
  assign y0_s = $signed({1'b0, pix_in.luma_first})  - $signed({1'b0, yuvrgb_pkg::LUMA_OFS});
  assign y1_s = $signed({1'b0, pix_in.luma_second}) - $signed({1'b0, yuvrgb_pkg::LUMA_OFS});

  assign r_term  = div256(yuvrgb_pkg::PROD_W'(cr_s) * yuvrgb_pkg::CR_TO_R);
  assign b_term  = div256(yuvrgb_pkg::PROD_W'(cb_s) * yuvrgb_pkg::CB_TO_B);
  assign g_term  = div256(yuvrgb_pkg::PROD_W'(cb_s) * yuvrgb_pkg::CB_TO_G)
                 + div256(yuvrgb_pkg::PROD_W'(cr_s) * yuvrgb_pkg::CR_TO_G);
  assign l0_term = div256(yuvrgb_pkg::PROD_W'(y0_s) * yuvrgb_pkg::LUMA_GAIN);
  assign l1_term = div256(yuvrgb_pkg::PROD_W'(y1_s) * yuvrgb_pkg::LUMA_GAIN);

  assign pix_out.red_first    = clamp8(l0_term + r_term);
  assign pix_out.green_first  = clamp8(l0_term + g_term);
  assign pix_out.blue_first   = clamp8(l0_term + b_term);
  assign pix_out.red_second   = clamp8(l1_term + r_term);
  assign pix_out.green_second = clamp8(l1_term + g_term);
  assign pix_out.blue_second  = clamp8(l1_term + b_term);

endmodule

/* hw/rtl/yuv_to_rgb_pixel_pair_converter_unit.sv */
// Channel   Ports                              Payload
// -------   --------------------------------   ---------------------------------
// input     in_valid, in_stall, in_data        yuvrgb_in_t  (Y0, Y1, Cb, Cr)
// output    out_valid, out_stall, out_data     yuvrgb_out_t (RGB of both pixels)
//
// One pixel pair per clock while out_stall is low; each transaction passes
// through the input register, then the result register, before out_valid
// shows its converted pair.
// The conversion sits in one combinational pass between those two registers.
// Reset (rst_n low, synchronous) clears both valid flags; payload is not reset.
// out_stall holds the result register; the input register keeps filling until
// it too holds a transaction, and only then is in_stall raised.
module yuv_to_rgb_pixel_pair_converter_unit (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  yuvrgb_pkg::yuvrgb_in_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output yuvrgb_pkg::yuvrgb_out_t out_data
);

  yuvrgb_pkg::yuvrgb_in_t  in_r;
  logic                    in_vld_r;
  yuvrgb_pkg::yuvrgb_out_t out_r;
  logic                    out_vld_r;
  yuvrgb_pkg::yuvrgb_out_t conv_rgb;

  logic out_adv;   // result register can take a new transaction this cycle
  logic in_adv;    // input register can take a new transaction this cycle

  assign out_adv  = !out_vld_r || !out_stall;
  assign in_adv   = !in_vld_r || out_adv;
  assign in_stall = !in_adv;

  yuvrgb_conv u_conv (
    .pix_in  (in_r),
    .pix_out (conv_rgb)
  );

  // Input register: capture a transaction whenever the stage drains or is empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_adv) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv && in_valid) begin
      in_r <= in_data;
    end
  end

  // Result register: advance the converted pair; hold it while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && in_vld_r) begin
      out_r <= conv_rgb;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
